// ===== rtl/lmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants for the LED-matrix chain frame controller.
// ----------------------------------------------------------------------------
package lmc_pkg;

	typedef enum logic [3:0] {
		ACT_SET_LED     = 4'd0,
		ACT_CLEAR_DEV   = 4'd1,
		ACT_WRITE_ROW   = 4'd2,
		ACT_SHIFT_LEFT  = 4'd3,
		ACT_SHIFT_RIGHT = 4'd4,
		ACT_ROTATE      = 4'd5,
		ACT_REFRESH     = 4'd6,
		ACT_INTENSITY   = 4'd7,
		ACT_SCANLIMIT   = 4'd8,
		ACT_SHUTDOWN    = 4'd9,
		ACT_RAW         = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_CLR,
		ST_RD,
		ST_OP,
		ST_ROTW
	} state_t;

	typedef enum logic [2:0] {
		PH_LED,
		PH_PRE,
		PH_SHIFT,
		PH_ROTL,
		PH_REF
	} phase_t;

	localparam logic [3:0] REG_INTENSITY = 4'd10;
	localparam logic [3:0] REG_SCAN      = 4'd11;
	localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
	localparam logic [7:0] INTENSITY_LIM = 8'd16;
	localparam logic [7:0] SCAN_LIM      = 8'd8;

endpackage

// ===== rtl/lmc_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_row_mem
// Row bitmap store: one write and one registered read port; entries read as
// zero until first written.
// ----------------------------------------------------------------------------
module lmc_row_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 8'h00;

endmodule

// ===== rtl/led_matrix_chain_frame_controller_top.sv =====
`timescale 1ns / 1ps
// Single-register commands pass through ST_ONE; set_led through ST_RD and ST_OP.
// Refresh reads then emits each row in turn, waiting while the output is stalled.
// Shift: carry preload from one end chip, a rewrite of every row, then refresh.
// Rotate goes chip by chip. One item at a time; in_ready is high only when idle.
// Reset makes all row bitmaps read as zero and sets num_devices to 8.
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_controller_top
// Keeps row bitmaps for a chain of LED-matrix driver chips and turns edit
// actions into register-write commands, one memory access per step.
// ----------------------------------------------------------------------------
module led_matrix_chain_frame_controller_top #(
	parameter int MAX_DEVICES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] action,
	input  logic [2:0] device,
	input  logic [2:0] row,
	input  logic [2:0] column,
	input  logic       led_on,
	input  logic [7:0] value,
	input  logic [3:0] opcode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] target_device,
	output logic [3:0] reg_opcode,
	output logic [7:0] reg_data,
	output logic       last
);
	import lmc_pkg::*;

	localparam int DEPTH = MAX_DEVICES * 8;
	localparam int AW    = $clog2(DEPTH);

	state_t        state_q, state_d;
	phase_t        phase_q, phase_d;
	logic          left_q, left_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic [2:0]    dev_q, dev_d;
	logic [2:0]    row_q, row_d;
	logic [2:0]    col_q, col_d;
	logic          on_q, on_d;
	logic [3:0]    cmd_op_q, cmd_op_d;
	logic [7:0]    cmd_data_q, cmd_data_d;
	logic [7:0]    carry_q;
	logic [7:0]    rb_q [8];
	logic [3:0]    num_dev_q;

	logic          out_valid_q;
	logic [2:0]    out_dev_q, out_dev_d;
	logic [3:0]    out_op_q, out_op_d;
	logic [7:0]    out_data_q, out_data_d;
	logic          out_last_q, out_last_d;
	logic          out_load, out_free;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, rdata;

	logic          carry_we, carry_bit, rb_we;
	logic [4:0]    n, nm1;
	logic [AW-1:0] last_idx;
	logic          dev_ok, acc;
	logic [7:0]    mask, rot_row;
	logic [2:0]    k;

	lmc_row_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// effective chain length, limited to 1..MAX_DEVICES
	always_comb begin
		if (num_dev_q == 4'd0) begin
			n = 5'd1;
		end else if ({1'b0, num_dev_q} > 5'(MAX_DEVICES)) begin
			n = 5'(MAX_DEVICES);
		end else begin
			n = {1'b0, num_dev_q};
		end
	end

	assign nm1      = n - 5'd1;
	assign last_idx = AW'({nm1, 3'b111});
	assign dev_ok   = {2'b00, device} < n;
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign mask     = 8'h80 >> col_q;
	assign k        = cnt_q[2:0];

	// column k (bit 7-k) of the loaded chip becomes row k
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			rot_row[b] = rb_q[b][3'd7 - k];
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		left_d     = left_q;
		cnt_d      = cnt_q;
		dev_d      = dev_q;
		row_d      = row_q;
		col_d      = col_q;
		on_d       = on_q;
		cmd_op_d   = cmd_op_q;
		cmd_data_d = cmd_data_q;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q;
		mem_wdata  = 8'h00;
		mem_re     = 1'b0;
		mem_raddr  = cnt_q;
		carry_we   = 1'b0;
		carry_bit  = 1'b0;
		rb_we      = 1'b0;
		out_load   = 1'b0;
		out_dev_d  = dev_q;
		out_op_d   = cmd_op_q;
		out_data_d = cmd_data_q;
		out_last_d = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					dev_d      = device;
					row_d      = row;
					col_d      = column;
					on_d       = led_on;
					cmd_data_d = value;
					cnt_d      = '0;
					case (action)
						ACT_SET_LED: begin
							if (dev_ok) begin
								phase_d = PH_LED;
								state_d = ST_RD;
							end
						end
						ACT_CLEAR_DEV: begin
							if (dev_ok) state_d = ST_CLR;
						end
						ACT_WRITE_ROW: begin
							if (dev_ok) begin
								mem_we    = 1'b1;
								mem_waddr = AW'({device, row});
								mem_wdata = value;
							end
						end
						ACT_SHIFT_LEFT, ACT_SHIFT_RIGHT: begin
							left_d  = (action == ACT_SHIFT_LEFT);
							phase_d = PH_PRE;
							state_d = ST_RD;
						end
						ACT_ROTATE: begin
							phase_d = PH_ROTL;
							state_d = ST_RD;
						end
						ACT_REFRESH: begin
							phase_d = PH_REF;
							state_d = ST_RD;
						end
						ACT_INTENSITY: begin
							cmd_op_d = REG_INTENSITY;
							if (dev_ok && value < INTENSITY_LIM) state_d = ST_ONE;
						end
						ACT_SCANLIMIT: begin
							cmd_op_d = REG_SCAN;
							if (dev_ok && value < SCAN_LIM) state_d = ST_ONE;
						end
						ACT_SHUTDOWN: begin
							cmd_op_d   = REG_SHUTDOWN;
							cmd_data_d = {7'd0, ~led_on};
							if (dev_ok) state_d = ST_ONE;
						end
						ACT_RAW: begin
							cmd_op_d = opcode;
							if (dev_ok) state_d = ST_ONE;
						end
						default: ;
					endcase
				end
			end
			ST_ONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CLR: begin
				if (out_free) begin
					mem_we     = 1'b1;
					mem_waddr  = AW'({dev_q, k});
					out_load   = 1'b1;
					out_op_d   = {1'b0, k} + 4'd1;
					out_data_d = 8'h00;
					out_last_d = (k == 3'd7);
					cnt_d      = cnt_q + AW'(1);
					if (k == 3'd7) state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				mem_re  = 1'b1;
				state_d = ST_OP;
				case (phase_q)
					PH_LED: mem_raddr = AW'({dev_q, row_q});
					PH_PRE: mem_raddr = left_q ? AW'({nm1, k}) : AW'(k);
					default: mem_raddr = cnt_q;
				endcase
			end
			ST_OP: begin
				case (phase_q)
					PH_LED: begin
						if (out_free) begin
							mem_we     = 1'b1;
							mem_waddr  = AW'({dev_q, row_q});
							mem_wdata  = on_q ? (rdata | mask) : (rdata & ~mask);
							out_load   = 1'b1;
							out_op_d   = {1'b0, row_q} + 4'd1;
							out_data_d = mem_wdata;
							state_d    = ST_IDLE;
						end
					end
					PH_PRE: begin
						carry_we  = 1'b1;
						carry_bit = left_q ? rdata[7] : rdata[0];
						state_d   = ST_RD;
						if (k == 3'd7) begin
							phase_d = PH_SHIFT;
							cnt_d   = left_q ? '0 : last_idx;
						end else begin
							cnt_d = cnt_q + AW'(1);
						end
					end
					PH_SHIFT: begin
						// rewrite the row and keep its outgoing bit for the row 8 further on
						mem_we    = 1'b1;
						mem_wdata = left_q ? {rdata[6:0], carry_q[k]} : {carry_q[k], rdata[7:1]};
						carry_we  = 1'b1;
						carry_bit = left_q ? rdata[7] : rdata[0];
						state_d   = ST_RD;
						if (left_q ? (cnt_q == last_idx) : (cnt_q == '0)) begin
							phase_d = PH_REF;
							cnt_d   = '0;
						end else begin
							cnt_d = left_q ? cnt_q + AW'(1) : cnt_q - AW'(1);
						end
					end
					PH_ROTL: begin
						rb_we = 1'b1;
						if (k == 3'd7) begin
							cnt_d   = cnt_q - AW'(7);
							state_d = ST_ROTW;
						end else begin
							cnt_d   = cnt_q + AW'(1);
							state_d = ST_RD;
						end
					end
					PH_REF: begin
						if (out_free) begin
							out_load   = 1'b1;
							out_dev_d  = 3'(cnt_q >> 3);
							out_op_d   = {1'b0, k} + 4'd1;
							out_data_d = rdata;
							out_last_d = (cnt_q == last_idx);
							cnt_d      = cnt_q + AW'(1);
							state_d    = (cnt_q == last_idx) ? ST_IDLE : ST_RD;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_ROTW: begin
				mem_we    = 1'b1;
				mem_wdata = rot_row;
				cnt_d     = cnt_q + AW'(1);
				if (k == 3'd7) begin
					if (cnt_q == last_idx) begin
						state_d = ST_IDLE;
					end else begin
						phase_d = PH_ROTL;
						state_d = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LED;
			num_dev_q   <= 4'd8;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cfg_valid && cfg_ready) begin
				num_dev_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		left_q     <= left_d;
		cnt_q      <= cnt_d;
		dev_q      <= dev_d;
		row_q      <= row_d;
		col_q      <= col_d;
		on_q       <= on_d;
		cmd_op_q   <= cmd_op_d;
		cmd_data_q <= cmd_data_d;
		if (carry_we) begin
			carry_q[k] <= carry_bit;
		end
		if (rb_we) begin
			rb_q[k] <= rdata;
		end
		if (out_load) begin
			out_dev_q  <= out_dev_d;
			out_op_q   <= out_op_d;
			out_data_q <= out_data_d;
			out_last_q <= out_last_d;
		end
	end

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign target_device = out_dev_q;
	assign reg_opcode    = out_op_q;
	assign reg_data      = out_data_q;
	assign last          = out_last_q;

endmodule

// ===== rtl/lmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_checker
// Port-level checks on the frame controller, bound to the top level.
// ----------------------------------------------------------------------------
module lmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] target_device,
	input logic [3:0] reg_opcode,
	input logic [7:0] reg_data,
	input logic       last
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reg_opcode)
		&& $stable(reg_data) && $stable(target_device) && $stable(last))
		else $error("output word changed while stalled");

	// only digit rows come in multi-word sequences
	a_digit_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> reg_opcode >= 4'd1 && reg_opcode <= 4'd8)
		else $error("non-final word is not a digit command");

	// mid-sequence the block takes no new item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input accepted in the middle of a command sequence");

endmodule

bind led_matrix_chain_frame_controller_top lmc_checker u_lmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.target_device(target_device),
	.reg_opcode   (reg_opcode),
	.reg_data     (reg_data),
	.last         (last)
);
